[src/i2cmbs_pkg.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer package
// Command codes, command item type, step phases and queue sizing shared by
// the front, queue and back of the sequencer.
// ---------------------------------------------------------------------------
package i2cmbs_pkg;

   localparam int OP_W = 2;
   localparam int BYTE_W = 8;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] byte_val;  // write byte or sampled read byte
      logic              ack_sda;   // SDA drive in the acknowledge slot
      logic              nak;       // slave acknowledge level of a write
   } cmd_type;

   typedef enum logic [1:0] {
      PH_SETUP,
      PH_HIGH,
      PH_LOW
   } phase_type;

   // bit groups 0..7 carry data, group 8 is the acknowledge slot
   localparam int GROUP_W = 4;
   localparam logic [GROUP_W-1:0] ACK_GROUP = 4'd8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

endpackage

[src/i2cmbs_front.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer front
// Accepts command items, classifies them and holds one decoded command
// until the queue takes it.
// ---------------------------------------------------------------------------
module i2cmbs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [i2cmbs_pkg::OP_W-1:0]   req_operation,
   input  logic [i2cmbs_pkg::BYTE_W-1:0] req_write_data,
   input  logic                          req_master_ack,
   input  logic [i2cmbs_pkg::BYTE_W-1:0] req_bus_read_byte,
   input  logic                          req_bus_ack_level,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output i2cmbs_pkg::cmd_type           cmd_data
);
   import i2cmbs_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req_ready = !valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;
   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      cmd_in = cmd_ff;
      if (take) begin
         unique case (req_operation)
            OP_START: begin
               cmd_in.kind     = KIND_START;
               cmd_in.byte_val = '0;
               cmd_in.ack_sda  = 1'b1;
               cmd_in.nak      = 1'b0;
            end
            OP_STOP: begin
               cmd_in.kind     = KIND_STOP;
               cmd_in.byte_val = '0;
               cmd_in.ack_sda  = 1'b1;
               cmd_in.nak      = 1'b0;
            end
            OP_WRITE: begin
               cmd_in.kind     = KIND_WRITE;
               cmd_in.byte_val = req_write_data;
               cmd_in.ack_sda  = 1'b1;
               cmd_in.nak      = req_bus_ack_level;
            end
            default: begin
               cmd_in.kind     = KIND_READ;
               cmd_in.byte_val = req_bus_read_byte;
               cmd_in.ack_sda  = !req_master_ack;
               cmd_in.nak      = 1'b0;
            end
         endcase
      end
   end

   assign valid_in = take || (valid_ff && !cmd_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

[src/i2cmbs_queue.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer command queue
// Short FIFO of decoded commands between the front and the back.
// ---------------------------------------------------------------------------
module i2cmbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  i2cmbs_pkg::cmd_type push_data,
   output logic                pop_valid,
   input  logic                pop,
   output i2cmbs_pkg::cmd_type pop_data
);
   import i2cmbs_pkg::*;

   cmd_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/i2cmbs_back.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer back
// Steps through the line drive sequence of one command at a time, one step
// per cycle while the result stage is free, into a registered result stage.
// ---------------------------------------------------------------------------
module i2cmbs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   input  i2cmbs_pkg::cmd_type           cmd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_scl,
   output logic                          rsp_sda,
   output logic                          rsp_last_step,
   output logic [i2cmbs_pkg::BYTE_W-1:0] rsp_read_data,
   output logic                          rsp_nak
);
   import i2cmbs_pkg::*;

   seq_state_type        state_ff, state_in;
   cmd_type              cur_ff, cur_in;
   phase_type            phase_ff, phase_in;
   logic [GROUP_W-1:0]   group_ff, group_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 valid_ff, valid_in;
   logic                 last_ff, last_in;
   logic [BYTE_W-1:0]    rdata_ff, rdata_in;
   logic                 nak_ff, nak_in;

   logic out_free, emit, last, load;
   logic step_scl, step_sda, data_bit;

   assign out_free = !valid_ff || rsp_ready;

   assign last = (phase_ff == PH_LOW) &&
                 ((cur_ff.kind == KIND_START) || (cur_ff.kind == KIND_STOP) ||
                  (group_ff == ACK_GROUP));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (cmd_valid) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (out_free && last && !cmd_valid) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      emit = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            load = cmd_valid;
         end
         SEQ_RUN: begin
            emit = out_free;
            load = out_free && last && cmd_valid;
         end
         default: begin
            emit = 1'b0;
            load = 1'b0;
         end
      endcase
   end

   assign cmd_pop  = load;
   assign data_bit = cur_ff.byte_val[~group_ff[2:0]];

   // line levels of the current step
   always_comb begin
      step_scl = scl_ff;
      step_sda = sda_ff;
      case (cur_ff.kind)
         KIND_START: begin
            case (phase_ff)
               PH_SETUP: step_scl = 1'b1;
               PH_HIGH:  step_sda = 1'b0;
               default: begin
                  step_scl = 1'b0;
                  step_sda = 1'b0;
               end
            endcase
         end
         KIND_STOP: begin
            case (phase_ff)
               PH_SETUP: step_sda = 1'b0;
               PH_HIGH:  step_scl = 1'b1;
               default:  step_sda = 1'b1;
            endcase
         end
         default: begin
            case (phase_ff)
               PH_SETUP: begin
                  if (group_ff == ACK_GROUP) begin
                     step_sda = cur_ff.ack_sda;
                  end else if (cur_ff.kind == KIND_WRITE) begin
                     step_sda = data_bit;
                  end else begin
                     step_sda = 1'b1;
                  end
               end
               PH_HIGH: step_scl = 1'b1;
               default: step_scl = 1'b0;
            endcase
         end
      endcase
   end

   always_comb begin
      cur_in   = cur_ff;
      phase_in = phase_ff;
      group_in = group_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      valid_in = valid_ff && !rsp_ready;
      last_in  = last_ff;
      rdata_in = rdata_ff;
      nak_in   = nak_ff;
      if (emit) begin
         scl_in   = step_scl;
         sda_in   = step_sda;
         valid_in = 1'b1;
         last_in  = last;
         rdata_in = (last && (cur_ff.kind == KIND_READ)) ? cur_ff.byte_val : '0;
         nak_in   = last && cur_ff.nak;
         if (phase_ff == PH_LOW) begin
            phase_in = PH_SETUP;
            group_in = group_ff + 1'b1;
         end else if (phase_ff == PH_SETUP) begin
            phase_in = PH_HIGH;
         end else begin
            phase_in = PH_LOW;
         end
      end
      if (load) begin
         cur_in   = cmd_data;
         phase_in = PH_SETUP;
         group_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         phase_ff <= PH_SETUP;
         group_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         group_ff <= group_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         valid_ff <= valid_in;
      end
      cur_ff   <= cur_in;
      last_ff  <= last_in;
      rdata_ff <= rdata_in;
      nak_ff   <= nak_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_scl       = scl_ff;
   assign rsp_sda       = sda_ff;
   assign rsp_last_step = last_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_nak       = nak_ff;

endmodule

[src/i2c_master_byte_sequencer_core.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer core
// Start and stop commands give 3 result items, write and read byte commands
// give 27, one result item per cycle while rsp_ready is high; each item is
// one line drive step with the SCL level and SDA drive (1 released). The
// line stepper in the back part sets the rate: one step per cycle while the
// result stage is free; a queued command follows the last step of the one
// before it back to back. A two-entry command queue sits between the front
// and the back, so commands are taken while earlier ones still run. Both
// lines read high after reset and keep their levels between commands.
// ---------------------------------------------------------------------------
module i2c_master_byte_sequencer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [i2cmbs_pkg::OP_W-1:0]   req_operation,
   input  logic [i2cmbs_pkg::BYTE_W-1:0] req_write_data,
   input  logic                          req_master_ack,
   input  logic [i2cmbs_pkg::BYTE_W-1:0] req_bus_read_byte,
   input  logic                          req_bus_ack_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_scl,
   output logic                          rsp_sda,
   output logic                          rsp_last_step,
   output logic [i2cmbs_pkg::BYTE_W-1:0] rsp_read_data,
   output logic                          rsp_nak
);
   import i2cmbs_pkg::*;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   i2cmbs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_write_data    (req_write_data),
      .req_master_ack    (req_master_ack),
      .req_bus_read_byte (req_bus_read_byte),
      .req_bus_ack_level (req_bus_ack_level),
      .cmd_valid         (front_valid),
      .cmd_ready         (front_ready),
      .cmd_data          (front_cmd)
   );

   i2cmbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_cmd)
   );

   i2cmbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_pop       (q_pop),
      .cmd_data      (q_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl       (rsp_scl),
      .rsp_sda       (rsp_sda),
      .rsp_last_step (rsp_last_step),
      .rsp_read_data (rsp_read_data),
      .rsp_nak       (rsp_nak)
   );

endmodule

[src/i2cmbs_checker.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer checker
// Port-level assertions on the result channel, bound to the core.
// ---------------------------------------------------------------------------
module i2cmbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_scl,
   input logic                          rsp_sda,
   input logic                          rsp_last_step,
   input logic [i2cmbs_pkg::BYTE_W-1:0] rsp_read_data,
   input logic                          rsp_nak
);
   import i2cmbs_pkg::*;

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_sda)
      && $stable(rsp_last_step) && $stable(rsp_read_data) && $stable(rsp_nak))
      else $error("result item changed while stalled");

   // status fields only on the final step
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_step |-> rsp_nak == 1'b0 && rsp_read_data == '0)
      else $error("status reported outside last step");

   // a command never ends with SCL high and SDA low
   a_end_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_step && rsp_scl |-> rsp_sda)
      else $error("command ended with SCL high and SDA low");

   // reset empties the result stage and releases the lines
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && rsp_scl && rsp_sda)
      else $error("bad state after reset");

endmodule

bind i2c_master_byte_sequencer_core i2cmbs_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_scl       (rsp_scl),
   .rsp_sda       (rsp_sda),
   .rsp_last_step (rsp_last_step),
   .rsp_read_data (rsp_read_data),
   .rsp_nak       (rsp_nak)
);

[tb/sv/i2c_master_byte_sequencer_core_tb.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer core testbench
// Drives start, stop, write byte and read byte commands into the core and
// predicts every SCL/SDA drive step from its own copy of the line levels.
// Stimulus is a directed set followed by random I2C transactions mixed with
// random commands. The sender idles and the receiver stalls in several
// phases. Each received step is checked field by field against the oldest
// predicted step.
// ---------------------------------------------------------------------------
module i2c_master_byte_sequencer_core_tb;
   import i2cmbs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 430;

   typedef struct {
      logic              scl;
      logic              sda;
      logic              last_step;
      logic [BYTE_W-1:0] read_data;
      logic              nak;
   } line_step_type;

   class line_step_checker;
      line_step_type expected_steps[$];
      logic          scl_level;
      logic          sda_level;
      int            failures;

      function new();
         scl_level = 1'b1;
         sda_level = 1'b1;
         failures = 0;
      endfunction

      function void push_step(logic scl, logic sda, logic last_step,
                              logic [BYTE_W-1:0] read_data, logic nak);
         line_step_type s;
         s.scl = scl;
         s.sda = sda;
         s.last_step = last_step;
         s.read_data = read_data;
         s.nak = nak;
         scl_level = scl;
         sda_level = sda;
         expected_steps.push_back(s);
      endfunction

      // predicted drive steps of one accepted command
      function void note_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] wdata,
                                 logic mack, logic [BYTE_W-1:0] rbyte,
                                 logic alvl);
         case (op)
            OP_START: begin
               push_step(1'b1, sda_level, 1'b0, '0, 1'b0);
               push_step(scl_level, 1'b0, 1'b0, '0, 1'b0);
               push_step(1'b0, sda_level, 1'b1, '0, 1'b0);
            end
            OP_STOP: begin
               push_step(scl_level, 1'b0, 1'b0, '0, 1'b0);
               push_step(1'b1, sda_level, 1'b0, '0, 1'b0);
               push_step(scl_level, 1'b1, 1'b1, '0, 1'b0);
            end
            OP_WRITE: begin
               for (int i = BYTE_W - 1; i >= 0; i--) begin
                  push_step(scl_level, wdata[i], 1'b0, '0, 1'b0);
                  push_step(1'b1, sda_level, 1'b0, '0, 1'b0);
                  push_step(1'b0, sda_level, 1'b0, '0, 1'b0);
               end
               push_step(scl_level, 1'b1, 1'b0, '0, 1'b0);
               push_step(1'b1, sda_level, 1'b0, '0, 1'b0);
               push_step(1'b0, sda_level, 1'b1, '0, alvl);
            end
            default: begin
               for (int i = 0; i < BYTE_W; i++) begin
                  push_step(scl_level, 1'b1, 1'b0, '0, 1'b0);
                  push_step(1'b1, sda_level, 1'b0, '0, 1'b0);
                  push_step(1'b0, sda_level, 1'b0, '0, 1'b0);
               end
               push_step(scl_level, !mack, 1'b0, '0, 1'b0);
               push_step(1'b1, sda_level, 1'b0, '0, 1'b0);
               push_step(1'b0, sda_level, 1'b1, rbyte, 1'b0);
            end
         endcase
      endfunction

      function void check_step(logic scl, logic sda, logic last_step,
                               logic [BYTE_W-1:0] read_data, logic nak);
         line_step_type e;
         if (expected_steps.size() == 0) begin
            $error("unexpected drive step: scl %0b sda %0b", scl, sda);
            failures++;
            return;
         end
         e = expected_steps.pop_front();
         if (scl !== e.scl) begin
            $error("scl: expected %0b, actual %0b", e.scl, scl);
            failures++;
         end
         if (sda !== e.sda) begin
            $error("sda: expected %0b, actual %0b", e.sda, sda);
            failures++;
         end
         if (last_step !== e.last_step) begin
            $error("last_step: expected %0b, actual %0b", e.last_step, last_step);
            failures++;
         end
         if (read_data !== e.read_data) begin
            $error("read_data: expected %02h, actual %02h", e.read_data, read_data);
            failures++;
         end
         if (nak !== e.nak) begin
            $error("nak: expected %0b, actual %0b", e.nak, nak);
            failures++;
         end
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_operation = OP_START;
   logic [BYTE_W-1:0] req_write_data = '0;
   logic              req_master_ack = 1'b0;
   logic [BYTE_W-1:0] req_bus_read_byte = '0;
   logic              req_bus_ack_level = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_scl;
   logic              rsp_sda;
   logic              rsp_last_step;
   logic [BYTE_W-1:0] rsp_read_data;
   logic              rsp_nak;

   line_step_checker steps;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               items_sent = 0;
   int               cycle_count = 0;

   i2c_master_byte_sequencer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_write_data    (req_write_data),
      .req_master_ack    (req_master_ack),
      .req_bus_read_byte (req_bus_read_byte),
      .req_bus_ack_level (req_bus_ack_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scl           (rsp_scl),
      .rsp_sda           (rsp_sda),
      .rsp_last_step     (rsp_last_step),
      .rsp_read_data     (rsp_read_data),
      .rsp_nak           (rsp_nak)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         steps.check_step(rsp_scl, rsp_sda, rsp_last_step, rsp_read_data, rsp_nak);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] wdata,
                               logic mack, logic [BYTE_W-1:0] rbyte, logic alvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_write_data <= wdata;
      req_master_ack <= mack;
      req_bus_read_byte <= rbyte;
      req_bus_ack_level <= alvl;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      steps.note_command(op, wdata, mack, rbyte, alvl);
      items_sent++;
   endtask

   // unused fields carry random values
   task automatic send_op(logic [OP_W-1:0] op);
      send_command(op, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom),
                   1'($urandom));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (steps.pending() != 0)
         @(posedge clock);
   endtask

   // start, address, a few data bytes, optional repeated start, optional stop
   task automatic run_transaction();
      logic [BYTE_W-1:0] addr;
      int                n;
      addr = BYTE_W'($urandom);
      n = $urandom_range(1, 4);
      send_op(OP_START);
      send_command(OP_WRITE, addr, 1'($urandom), BYTE_W'($urandom),
                   $urandom_range(99) < 15);
      for (int i = 0; i < n; i++) begin
         if (addr[0])
            send_command(OP_READ, BYTE_W'($urandom), i != n - 1, BYTE_W'($urandom),
                         1'($urandom));
         else
            send_command(OP_WRITE, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom),
                         $urandom_range(99) < 20);
      end
      if ($urandom_range(99) < 20) begin
         send_op(OP_START);
         send_command(OP_WRITE, addr | 8'h01, 1'($urandom), BYTE_W'($urandom), 1'b0);
         send_command(OP_READ, BYTE_W'($urandom), 1'b0, BYTE_W'($urandom),
                      1'($urandom));
      end
      if ($urandom_range(99) < 90)
         send_op(OP_STOP);
   endtask

   task automatic run_random_phase(int idle_pct, int stall_pct, int count);
      int target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99) < 80)
            run_transaction();
         else
            send_command(OP_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                         BYTE_W'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      steps = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
      send_command(OP_START, 8'hFF, 1'b1, 8'hFF, 1'b1);
      send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
      send_command(OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0);
      send_command(OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1);
      send_command(OP_WRITE, 8'hA5, 1'b0, 8'h3C, 1'b1);
      send_command(OP_WRITE, 8'h5A, 1'b1, 8'hC3, 1'b0);
      send_command(OP_READ, 8'hFF, 1'b1, 8'h00, 1'b1);
      send_command(OP_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
      send_command(OP_READ, 8'h96, 1'b1, 8'h5A, 1'b0);
      send_command(OP_READ, 8'h69, 1'b0, 8'hA5, 1'b1);
      send_command(OP_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1);
      send_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
      send_command(OP_READ, 8'h01, 1'b1, 8'h80, 1'b1);
      send_command(OP_START, 8'h80, 1'b1, 8'h01, 1'b0);
      send_command(OP_WRITE, 8'h01, 1'b0, 8'h80, 1'b0);
      send_command(OP_WRITE, 8'h80, 1'b1, 8'h01, 1'b1);
      send_command(OP_STOP, 8'h7F, 1'b0, 8'hFE, 1'b1);

      run_random_phase(0, 0, RANDOM_ITEMS / 4);
      run_random_phase(45, 0, RANDOM_ITEMS / 4);
      wait_for_drain();
      run_random_phase(0, 45, RANDOM_ITEMS / 4);
      run_random_phase(31, 31, RANDOM_ITEMS / 4);

      req_valid <= 1'b0;
      while (steps.pending() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (steps.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
src/i2cmbs_pkg.sv
src/i2cmbs_front.sv
src/i2cmbs_queue.sv
src/i2cmbs_back.sv
src/i2c_master_byte_sequencer_core.sv
src/i2cmbs_checker.sv
tb/sv/i2c_master_byte_sequencer_core_tb.sv
